@@ hw/rtl/jsud_pkg.sv @@
// shared types and codes for the json string unescape decoder
package jsud_pkg;

    // one input item: a raw text byte or an end-of-text marker
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } t_in_item;

    // one result item as seen on the output channel
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] error_code;
        logic       last_of_run;
    } t_out_item;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_QUOTE   = 2'd0;
    localparam logic [1:0] ERR_UNICODE = 2'd1;
    localparam logic [1:0] ERR_ESCAPE  = 2'd2;
    localparam logic [1:0] ERR_UNTERM  = 2'd3;

    localparam int unsigned MAX_RUN = 3;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_count;
        logic [15:0] code_point;
        logic        hex_stopped;
    } t_state;

    // one result without its position in the run
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] error_code;
    } t_res;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]             count;
        t_res [MAX_RUN-1:0]     res;
    } t_run;

endpackage

@@ hw/rtl/json_string_unescape_decoder.sv @@
// top level of the json string unescape decoder
//
// input channel: one item per byte of a json string token, starting at its
// opening quote; an item with text_end set marks the end of the text
// output channel: decoded bytes, a done item at the closing quote, or an
// error item; last_of_run marks the final result caused by one input item
// each input item is decoded in the cycle it is accepted, against the
// registered decoder state, and its zero to three results land in a run
// buffer; the first result is shown in the cycle after acceptance
// throughput: one input item per cycle while each item gives at most one
// result and the output is not stalled; a \u escape that encodes to two
// or three utf-8 bytes holds the input while the run buffer drains
// a new item is taken in the same cycle the last result of the previous run
// leaves, so there is no bubble between runs
// stall on the output holds the shown result and, once the buffer is full,
// raises stall on the input
// reset (synchronous, active low) empties the run buffer and returns the
// decoder to waiting for an opening quote
module json_string_unescape_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  jsud_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jsud_pkg::t_out_item o_out_item
);
    import jsud_pkg::*;

    // decoder state
    t_state     r_state;
    t_state     n_state;
    // run buffer: results of one item, count and read position
    t_run       r_run;
    t_run       step_run;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;

    logic       out_take;
    logic       run_last;
    logic       buf_free;
    logic       in_accept;
    t_res       cur_res;

    jsud_step u_step (
        .i_state (r_state),
        .i_item  (i_in_item),
        .o_state (n_state),
        .o_run   (step_run)
    );

    // handshake bookkeeping
    assign o_out_valid = (r_cnt != 2'd0);
    assign out_take    = o_out_valid && !i_out_stall;
    assign run_last    = (r_idx == r_cnt - 2'd1);
    // buffer can take a new run when empty or when its last result leaves now
    assign buf_free    = !o_out_valid || (out_take && run_last);
    assign o_in_stall  = !buf_free;
    assign in_accept   = i_in_valid && buf_free;

    // pick the result at the read position
    always_comb begin
        case (r_idx)
            2'd0:    cur_res = r_run.res[0];
            2'd1:    cur_res = r_run.res[1];
            2'd2:    cur_res = r_run.res[2];
            default: cur_res = r_run.res[0];
        endcase
    end

    assign o_out_item = '{cur_res.kind, cur_res.data_byte, cur_res.error_code, run_last};

    // control: decoder state, count, position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{MODE_WAIT, 2'd0, 16'h0000, 1'b0};
            r_cnt   <= 2'd0;
            r_idx   <= 2'd0;
        end else if (in_accept) begin
            r_state <= n_state;
            r_cnt   <= step_run.count;
            r_idx   <= 2'd0;
        end else if (out_take) begin
            if (run_last) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // payload: results of the accepted item
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_run <= step_run;
        end
    end

endmodule

@@ hw/rtl/jsud_step.sv @@
// combinational decode of one input item against the current decoder state
module jsud_step (
    input  jsud_pkg::t_state   i_state,
    input  jsud_pkg::t_in_item i_item,
    output jsud_pkg::t_state   o_state,
    output jsud_pkg::t_run     o_run
);
    import jsud_pkg::*;

    logic [7:0]  c;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp_next;

    assign c = i_item.text_byte;

    // hex digit value of the current byte, either case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            hex_val = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_val = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp_next = (i_state.hex_stopped || !hex_ok) ? i_state.code_point
                                                      : {i_state.code_point[11:0], hex_val};

    always_comb begin
        o_state = i_state;
        o_run   = '0;
        case (i_state.mode)
            MODE_WAIT: begin
                if (!i_item.text_end && c == 8'h22) begin
                    o_state.mode = MODE_STR;
                end else begin
                    o_run.count  = 2'd1;
                    o_run.res[0] = '{KIND_ERR, 8'h00, ERR_QUOTE};
                end
            end
            MODE_STR: begin
                if (i_item.text_end) begin
                    o_state.mode = MODE_WAIT;
                    o_run.count  = 2'd1;
                    o_run.res[0] = '{KIND_ERR, 8'h00, ERR_UNTERM};
                end else if (c == 8'h22) begin
                    o_state.mode = MODE_WAIT;
                    o_run.count  = 2'd1;
                    o_run.res[0] = '{KIND_DONE, 8'h00, ERR_QUOTE};
                end else if (c == 8'h5C) begin
                    o_state.mode = MODE_ESC;
                end else begin
                    o_run.count  = 2'd1;
                    o_run.res[0] = '{KIND_BYTE, c, ERR_QUOTE};
                end
            end
            MODE_ESC: begin
                if (i_item.text_end) begin
                    o_state.mode = MODE_WAIT;
                    o_run.count  = 2'd1;
                    o_run.res[0] = '{KIND_ERR, 8'h00, ERR_UNTERM};
                end else begin
                    o_state.mode = MODE_STR;
                    o_run.count  = 2'd1;
                    case (c)
                        8'h22, 8'h5C, 8'h2F: o_run.res[0] = '{KIND_BYTE, c, ERR_QUOTE};
                        8'h6E: o_run.res[0] = '{KIND_BYTE, 8'h0A, ERR_QUOTE};
                        8'h72: o_run.res[0] = '{KIND_BYTE, 8'h0D, ERR_QUOTE};
                        8'h74: o_run.res[0] = '{KIND_BYTE, 8'h09, ERR_QUOTE};
                        8'h62: o_run.res[0] = '{KIND_BYTE, 8'h08, ERR_QUOTE};
                        8'h66: o_run.res[0] = '{KIND_BYTE, 8'h0C, ERR_QUOTE};
                        8'h75: begin
                            o_state.mode        = MODE_HEX;
                            o_state.hex_count   = 2'd0;
                            o_state.code_point  = 16'h0000;
                            o_state.hex_stopped = 1'b0;
                            o_run.count         = 2'd0;
                        end
                        default: begin
                            o_state.mode = MODE_WAIT;
                            o_run.res[0] = '{KIND_ERR, 8'h00, ERR_ESCAPE};
                        end
                    endcase
                end
            end
            MODE_HEX: begin
                if (i_item.text_end) begin
                    o_state.mode = MODE_WAIT;
                    o_run.count  = 2'd1;
                    o_run.res[0] = '{KIND_ERR, 8'h00, ERR_UNICODE};
                end else begin
                    o_state.code_point  = cp_next;
                    o_state.hex_stopped = i_state.hex_stopped | ~hex_ok;
                    if (i_state.hex_count != 2'd3) begin
                        o_state.hex_count = i_state.hex_count + 2'd1;
                    end else begin
                        o_state.hex_count = 2'd0;
                        o_state.mode      = MODE_STR;
                        // utf-8 encode, one to three bytes
                        if (cp_next[15:7] == '0) begin
                            o_run.count  = 2'd1;
                            o_run.res[0] = '{KIND_BYTE, cp_next[7:0], ERR_QUOTE};
                        end else if (cp_next[15:11] == '0) begin
                            o_run.count  = 2'd2;
                            o_run.res[0] = '{KIND_BYTE, {3'b110, cp_next[10:6]}, ERR_QUOTE};
                            o_run.res[1] = '{KIND_BYTE, {2'b10, cp_next[5:0]}, ERR_QUOTE};
                        end else begin
                            o_run.count  = 2'd3;
                            o_run.res[0] = '{KIND_BYTE, {4'b1110, cp_next[15:12]}, ERR_QUOTE};
                            o_run.res[1] = '{KIND_BYTE, {2'b10, cp_next[11:6]}, ERR_QUOTE};
                            o_run.res[2] = '{KIND_BYTE, {2'b10, cp_next[5:0]}, ERR_QUOTE};
                        end
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

@@ hw/rtl/jsud_checker.sv @@
// port-level checks for the json string unescape decoder, bound to the top level
module jsud_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input jsud_pkg::t_out_item o_out_item
);
    import jsud_pkg::*;

    // a stalled result stays shown and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // done and error items always close their run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != KIND_BYTE |-> o_out_item.last_of_run)
        else $error("done or error item not last of run");

    // non-byte items carry a zero data byte, and only errors carry an error code
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.kind == KIND_BYTE || o_out_item.data_byte == 8'h00)
                     && (o_out_item.kind == KIND_ERR || o_out_item.error_code == 2'd0))
        else $error("unused result field not zero");

    // kind is one of byte, done, error
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.kind == KIND_BYTE || o_out_item.kind == KIND_DONE
                     || o_out_item.kind == KIND_ERR)
        else $error("illegal result kind");

endmodule

bind json_string_unescape_decoder jsud_checker u_jsud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
